[hw/rtl/dvss_pkg.sv]
// shared types, glyph table and decimal split helpers for the dual value scanner
package dvss_pkg;

  localparam int unsigned VALUE_W = 10;
  localparam int unsigned CODE_W  = 5;
  localparam int unsigned NUM_DIGITS = 8;
  localparam int unsigned POS_W   = 4;

  typedef logic [CODE_W-1:0] code_t;

  localparam code_t CODE_BLANK = 5'd0;
  localparam code_t CODE_MINUS = 5'd17;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd999;
  localparam logic [7:0] GLYPH_MINUS = 8'hBF;
  localparam logic [7:0] GLYPH_BLANK = 8'hFF;
  localparam logic [7:0] DP_BIT      = 8'h80;

  localparam logic [POS_W-1:0] POS_FIRST = 4'd1;
  localparam logic [POS_W-1:0] POS_LAST  = 4'd8;

  localparam logic [7:0] GLYPH_DIGIT [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  // one value split into hundreds and the rest below one hundred
  typedef struct packed {
    logic [3:0] hund;
    logic [6:0] rem;
  } dec_split_t;

  // captured transaction after the first split step
  typedef struct packed {
    logic       over;
    dec_split_t first;
    dec_split_t second;
  } split_t;

  // floor(v / 100) for v below 1024
  function automatic logic [3:0] hund_of(input logic [VALUE_W-1:0] v);
    logic [15:0] prod;
    prod = 16'(v) * 16'd41;
    return prod[15:12];
  endfunction

  // floor(r / 10) for r below 100
  function automatic logic [3:0] tens_of(input logic [6:0] r);
    logic [13:0] prod;
    prod = 14'(r) * 14'd103;
    return prod[13:10];
  endfunction

  function automatic logic [7:0] glyph_of(input code_t code);
    logic [7:0] g;
    if (code >= 5'd1 && code <= 5'd10) begin
      g = GLYPH_DIGIT[4'(code - 5'd1)];
    end else if (code == CODE_MINUS) begin
      g = GLYPH_MINUS;
    end else begin
      g = GLYPH_BLANK;
    end
    return g;
  endfunction

endpackage

[hw/rtl/dvss_if.sv]
// valid/ready channel interfaces for the input values and the display results
interface dvss_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] first_value;
  logic [9:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface dvss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] segment_byte;
  logic [7:0] select_byte;
  logic [3:0] digit_position;
  logic       frame_start;

  modport source (
    output valid, output segment_byte, output select_byte,
    output digit_position, output frame_start, input ready
  );
  modport sink (
    input valid, input segment_byte, input select_byte,
    input digit_position, input frame_start, output ready
  );
endinterface

[hw/rtl/dvss_split.sv]
// input register stage: captures both values with their hundreds split out
module dvss_split (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [9:0]        in_first,
  input  logic [9:0]        in_second,
  output logic              stg_valid,
  input  logic              stg_ready,
  output dvss_pkg::split_t  stg_data
);
  import dvss_pkg::*;

  logic   valid_r;
  split_t data_r;
  split_t data_nxt;
  logic [3:0] hund_a;
  logic [3:0] hund_b;

  always_comb begin
    hund_a = hund_of(in_first);
    hund_b = hund_of(in_second);
    data_nxt.over        = (in_first > VALUE_MAX) || (in_second > VALUE_MAX);
    data_nxt.first.hund  = hund_a;
    data_nxt.first.rem   = 7'(in_first - 10'(hund_a) * 10'd100);
    data_nxt.second.hund = hund_b;
    data_nxt.second.rem  = 7'(in_second - 10'(hund_b) * 10'd100);
  end

  assign in_ready  = !valid_r || stg_ready;
  assign stg_valid = valid_r;
  assign stg_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

[hw/rtl/dvss_scan.sv]
// scan stage: position counter, digit buffer reload and the result register
module dvss_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        point_mask,
  input  logic              stg_valid,
  output logic              stg_ready,
  input  dvss_pkg::split_t  stg_data,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [7:0]        res_segment,
  output logic [7:0]        res_select,
  output logic [3:0]        res_position,
  output logic              res_frame
);
  import dvss_pkg::*;

  logic [POS_W-1:0] scan_r;
  logic [POS_W-1:0] scan_nxt;
  code_t            codes_r   [NUM_DIGITS];
  code_t            codes_nxt [NUM_DIGITS];
  logic             wrap;
  logic             advance;
  logic [2:0]       idx;
  logic [3:0]       a_tens;
  logic [3:0]       a_ones;
  logic [3:0]       b_tens;
  logic [3:0]       b_ones;
  logic [7:0]       seg;

  logic             valid_r;
  logic [7:0]       seg_r;
  logic [7:0]       sel_r;
  logic [POS_W-1:0] pos_r;
  logic             frame_r;

  assign stg_ready = !valid_r || res_ready;
  assign advance   = stg_valid && stg_ready;

  always_comb begin
    wrap = 1'b0;
    if (scan_r == POS_LAST) begin
      scan_nxt = POS_FIRST;
      wrap     = 1'b1;
    end else if (scan_r >= POS_FIRST && scan_r < POS_LAST) begin
      scan_nxt = scan_r + 4'd1;
    end else begin
      scan_nxt = POS_FIRST;
    end
  end

  always_comb begin
    a_tens = tens_of(stg_data.first.rem);
    b_tens = tens_of(stg_data.second.rem);
    a_ones = 4'(stg_data.first.rem - {a_tens, 3'b000} - {2'b00, a_tens, 1'b0});
    b_ones = 4'(stg_data.second.rem - {b_tens, 3'b000} - {2'b00, b_tens, 1'b0});
  end

  always_comb begin
    codes_nxt = codes_r;
    if (wrap) begin
      if (stg_data.over) begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          codes_nxt[i] = CODE_BLANK;
        end
      end else begin
        codes_nxt[7] = 5'(stg_data.first.hund) + 5'd1;
        codes_nxt[6] = 5'(a_tens) + 5'd1;
        codes_nxt[5] = 5'(a_ones) + 5'd1;
        codes_nxt[4] = CODE_MINUS;
        codes_nxt[3] = CODE_MINUS;
        codes_nxt[2] = 5'(stg_data.second.hund) + 5'd1;
        codes_nxt[1] = 5'(b_tens) + 5'd1;
        codes_nxt[0] = 5'(b_ones) + 5'd1;
      end
    end
  end

  always_comb begin
    idx = 3'(scan_nxt - 4'd1);
    seg = glyph_of(codes_nxt[idx]);
    if (point_mask[idx]) begin
      seg = seg & ~DP_BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        codes_r[i] <= CODE_BLANK;
      end
    end else if (advance) begin
      scan_r  <= scan_nxt;
      codes_r <= codes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (stg_ready) begin
      valid_r <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      seg_r   <= seg;
      sel_r   <= 8'b1 << idx;
      pos_r   <= scan_nxt;
      frame_r <= wrap;
    end
  end

  assign res_valid    = valid_r;
  assign res_segment  = seg_r;
  assign res_select   = sel_r;
  assign res_position = pos_r;
  assign res_frame    = frame_r;

endmodule

[hw/rtl/dual_value_seven_segment_scanner.sv]
// top level of the dual value multiplexed seven segment scanner
//
// each transaction on in_ch is one refresh tick carrying two values; each
// produces exactly one transaction on out_ch with the segment byte (active
// low, bit 7 decimal point), the one-hot digit select, the scan position
// 1..8 and a frame start flag set when the scan wrapped and the eight digit
// buffer was reloaded from this tick's values (left value, two minus signs,
// right value; all blank if either value is above 999).
// an accepted transaction passes the input register and then the result
// register; one transaction per cycle is sustained while out_ch is ready.
// the path is an input register that splits off the hundreds and a result
// register fed by the tens/ones split, scan counter and glyph lookup.
// when out_ch stalls the result register holds, the input register still
// takes one more transaction, then in_ch.ready drops.
// reset clears the scan position to zero, blanks the buffer and sets
// point_mask to 0x42; the first tick after reset shows position 1 blank
// with no frame start. cfg_we writes point_mask from cfg_data.
module dual_value_seven_segment_scanner (
  input  logic       clk,
  input  logic       rst_n,
  dvss_in_if.sink    in_ch,
  dvss_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);
  import dvss_pkg::*;

  logic [7:0] point_mask_r;
  logic       stg_valid;
  logic       stg_ready;
  split_t     stg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_mask_r <= 8'h42;
    end else if (cfg_we) begin
      point_mask_r <= cfg_data;
    end
  end

  dvss_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_first  (in_ch.first_value),
    .in_second (in_ch.second_value),
    .stg_valid (stg_valid),
    .stg_ready (stg_ready),
    .stg_data  (stg_data)
  );

  dvss_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_mask   (point_mask_r),
    .stg_valid    (stg_valid),
    .stg_ready    (stg_ready),
    .stg_data     (stg_data),
    .res_valid    (out_ch.valid),
    .res_ready    (out_ch.ready),
    .res_segment  (out_ch.segment_byte),
    .res_select   (out_ch.select_byte),
    .res_position (out_ch.digit_position),
    .res_frame    (out_ch.frame_start)
  );

endmodule
